@@ design/nvs_pkg.sv @@
// Shared types and constants for the NV12/NV21 nearest-neighbor scaler.
// Used by nvs_ratio and nv_frame_nearest_scaler; depends on nothing.
`default_nettype none
package nvs_pkg;

    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned RATIO_W  = 24;
    localparam int unsigned SIZE_W   = 8;
    localparam int unsigned CNT_W    = 5;
    localparam logic [SIZE_W-1:0] ALIGN_MASK = 8'hF8;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic               busy;
        logic [RATIO_W-1:0] x_ratio;
        logic [RATIO_W-1:0] y_ratio;
    } nvs_ratio_t;

endpackage
`default_nettype wire

@@ design/nvs_ratio.sv @@
// Step ratio unit: (source << 16) / target + 1 for columns, then rows, by a
// shared restoring divider that produces one quotient bit a cycle. Uses nvs_pkg.
`default_nettype none
module nvs_ratio
    import nvs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SIZE_W-1:0] source_width,
    input  wire logic [SIZE_W-1:0] source_height,
    input  wire logic [SIZE_W-1:0] target_width,
    input  wire logic [SIZE_W-1:0] target_height,
    output nvs_ratio_t             status
);

    logic               busy_reg;
    logic               phase_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic [RATIO_W-1:0] dvd_reg;
    logic [RATIO_W-1:0] quo_reg;
    logic [RATIO_W-1:0] x_ratio_reg;
    logic [RATIO_W-1:0] y_ratio_reg;

    logic [SIZE_W-1:0]  divisor;
    logic [SIZE_W:0]    trial;
    logic [SIZE_W:0]    diff;
    logic               ge;
    logic [RATIO_W-1:0] quo_next;
    logic [SIZE_W-1:0]  rem_next;

    always_comb
    begin
        divisor  = phase_reg ? target_height : target_width;
        trial    = {rem_reg, dvd_reg[RATIO_W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        quo_next = {quo_reg[RATIO_W-2:0], ge};
        rem_next = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            dvd_reg     <= '0;
            quo_reg     <= '0;
            x_ratio_reg <= RATIO_W'(32'h0001_0001);
            y_ratio_reg <= RATIO_W'(32'h0001_0001);
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dvd_reg   <= {source_width, {FRAC_W{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(RATIO_W - 1))
            begin
                cnt_reg <= '0;
                rem_reg <= '0;
                quo_reg <= '0;
                if (!phase_reg)
                begin
                    x_ratio_reg <= quo_next + RATIO_W'(1);
                    phase_reg   <= 1'b1;
                    dvd_reg     <= {source_height, {FRAC_W{1'b0}}};
                end
                else
                begin
                    y_ratio_reg <= quo_next + RATIO_W'(1);
                    busy_reg    <= 1'b0;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                dvd_reg <= {dvd_reg[RATIO_W-2:0], 1'b0};
            end
        end
    end

    assign status.busy    = busy_reg;
    assign status.x_ratio = x_ratio_reg;
    assign status.y_ratio = y_ratio_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !phase_reg)
        else $error("divider did not start");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < CNT_W'(RATIO_W))
        else $error("divider step count out of range");

    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> phase_reg)
        else $error("divider finished before the row ratio");

endmodule
`default_nettype wire

@@ design/nv_frame_nearest_scaler.sv @@
// Top level of the NV12/NV21 nearest-neighbor scaler: frame store, read
// address pipeline and output register. Uses nvs_pkg and nvs_ratio.
//
// The slave channel carries one word per command. s_tuser[0] selects a store
// (0) or a read (1). A store writes one source byte into the frame store and
// returns nothing; stores are taken one per cycle while s_tready is high. A read
// names a destination plane, row and column and returns one word on the master
// channel: the nearest source byte in m_tdata and the coverage flag in m_tuser.
// A read passes through two multiply stages, the address add with the registered
// frame store read, and the output register; the next command is taken once the
// read has left the pipeline.
// The size registers are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while the block is idle, and the block does not enforce
// this. Each write restarts the step ratio divider, which holds s_tready low
// until both ratios are done. After reset all sizes are 128 and the ratios are
// ready at once; the frame store contents are undefined until written.
// When the receiver stalls, the finished word waits in the output register;
// stores are still taken, and one more read is taken and waits at its last stage.
`default_nettype none
module nv_frame_nearest_scaler
    import nvs_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 128,
    parameter int unsigned MAX_HEIGHT = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // store_address[14:0], store_data[22:15], row[29:23], column[36:30], zero
    input  wire logic [39:0] s_tdata,
    // operation[0], plane[1]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_byte[7:0]
    output logic [7:0]       m_tdata,
    // covered[0]
    output logic             m_tuser,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam logic [31:0] DEPTH32 = 32'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LIN  = 5'b00100,
        S_ADDR = 5'b01000,
        S_DATA = 5'b10000
    } state_t;

    state_t state_reg;

    logic [SIZE_W-1:0] source_width_reg;
    logic [SIZE_W-1:0] source_height_reg;
    logic [SIZE_W-1:0] target_width_reg;
    logic [SIZE_W-1:0] target_height_reg;
    logic              start_reg;
    logic [15:0]       sarea_reg;
    logic [15:0]       tarea_reg;

    nvs_ratio_t ratio;

    logic [7:0] frame_mem [DEPTH];
    logic [7:0] rdata_reg;

    logic        plane_reg;
    logic [6:0]  row_reg;
    logic [6:0]  col_reg;
    logic [31:0] sy_prod_reg;
    logic [31:0] sx_prod_reg;
    logic [14:0] eq_prod_reg;
    logic [23:0] row_off_reg;
    logic [15:0] sx_eff_reg;
    logic [16:0] eq_off_reg;
    logic        cov_reg;
    logic        hit_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_cov_reg;

    logic        accept;
    logic        store_hit;
    logic [14:0] in_store_address;
    logic [7:0]  in_store_data;
    logic [6:0]  in_row;
    logic [6:0]  in_col;
    logic        out_free;
    logic [7:0]  y8;
    logic [6:0]  x7;
    logic [15:0] sy16;
    logic [15:0] sx16;
    logic [15:0] sy_eff;
    logic [15:0] sx_eff;
    logic [16:0] eq_off;
    logic [25:0] sc_addr;
    logic [31:0] fetch_addr;
    logic [16:0] total;
    logic [7:0]  wm;
    logic [7:0]  hm;
    logic        equal_size;
    logic        eq_cov;
    logic        sc_cov;

    assign in_store_address = s_tdata[14:0];
    assign in_store_data    = s_tdata[22:15];
    assign in_row           = s_tdata[29:23];
    assign in_col           = s_tdata[36:30];

    assign s_tready  = (state_reg == S_IDLE) && !start_reg && !ratio.busy;
    assign accept    = s_tvalid && s_tready;
    assign store_hit = accept && (s_tuser[0] == OP_STORE)
                       && (32'(in_store_address) < DEPTH32);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        y8         = plane_reg ? {row_reg, 1'b0} : {1'b0, row_reg};
        x7         = plane_reg ? {col_reg[6:1], 1'b0} : col_reg;
        sy16       = sy_prod_reg[31:16];
        sx16       = sx_prod_reg[31:16];
        sy_eff     = plane_reg ? {1'b0, sy16[15:1]} : sy16;
        sx_eff     = plane_reg ? {sx16[15:1], 1'b0} : sx16;
        eq_off     = 17'(eq_prod_reg) + 17'(col_reg) + (plane_reg ? 17'(tarea_reg) : 17'd0);
        sc_addr    = 26'(row_off_reg) + 26'(sx_eff_reg)
                     + (plane_reg ? 26'(sarea_reg) + 26'(col_reg[0]) : 26'd0);
        total      = 17'(tarea_reg) + 17'(tarea_reg[15:1]);
        wm         = target_width_reg & ALIGN_MASK;
        hm         = target_height_reg & ALIGN_MASK;
        equal_size = (source_width_reg == target_width_reg)
                     && (source_height_reg == target_height_reg);
        eq_cov     = ({1'b0, col_reg} < target_width_reg)
                     && (plane_reg || ({1'b0, row_reg} < target_height_reg))
                     && (eq_off_reg < total);
        sc_cov     = (target_width_reg != '0) && (target_height_reg != '0)
                     && (y8 < hm) && ({1'b0, col_reg} < wm);
        fetch_addr = equal_size ? 32'(eq_off_reg) : 32'(sc_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= 8'd128;
            source_height_reg <= 8'd128;
            target_width_reg  <= 8'd128;
            target_height_reg <= 8'd128;
            start_reg         <= 1'b0;
            sarea_reg         <= 16'd16384;
            tarea_reg         <= 16'd16384;
        end
        else
        begin
            start_reg <= cfg_write;
            sarea_reg <= source_width_reg * source_height_reg;
            tarea_reg <= target_width_reg * target_height_reg;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                    REG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                    REG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                    REG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                    default:           source_width_reg  <= source_width_reg;
                endcase
            end
        end
    end

    nvs_ratio u_ratio (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start_reg),
        .source_width  (source_width_reg),
        .source_height (source_height_reg),
        .target_width  (target_width_reg),
        .target_height (target_height_reg),
        .status        (ratio)
    );

    always_ff @(posedge clk)
    begin
        if (store_hit)
        begin
            frame_mem[AW'(in_store_address)] <= in_store_data;
        end
        if (state_reg == S_ADDR)
        begin
            rdata_reg <= frame_mem[fetch_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plane_reg <= s_tuser[1];
            row_reg   <= in_row;
            col_reg   <= in_col;
        end
        if (state_reg == S_MUL)
        begin
            sy_prod_reg <= 32'(y8) * 32'(ratio.y_ratio);
            sx_prod_reg <= 32'(x7) * 32'(ratio.x_ratio);
            eq_prod_reg <= row_reg * target_width_reg;
        end
        if (state_reg == S_LIN)
        begin
            row_off_reg <= 24'(sy_eff) * 24'(source_width_reg);
            sx_eff_reg  <= sx_eff;
            eq_off_reg  <= eq_off;
        end
        if (state_reg == S_ADDR)
        begin
            cov_reg <= equal_size ? eq_cov : sc_cov;
            hit_reg <= fetch_addr < DEPTH32;
        end
        if ((state_reg == S_DATA) && out_free)
        begin
            out_data_reg <= (cov_reg && hit_reg) ? rdata_reg : 8'd0;
            out_cov_reg  <= cov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready && !((state_reg == S_DATA) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (s_tuser[0] == OP_READ))
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:  state_reg <= S_LIN;
                S_LIN:  state_reg <= S_ADDR;
                S_ADDR: state_reg <= S_DATA;
                S_DATA:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_cov_reg;

    a_ready_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !ratio.busy)
        else $error("command taken while the step ratios are being computed");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !s_tready)
        else $error("command taken right after a size write");

    a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser || (m_tdata == 8'd0)))
        else $error("uncovered word carries a nonzero byte");

    a_read_reaches_data: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser[0] == OP_READ)) |-> ##4 (state_reg == S_DATA))
        else $error("read did not reach the frame store stage");

endmodule
`default_nettype wire
